FILE: sv/rhlg_pkg.sv
`default_nettype none

package rhlg_pkg;

  // LED frame geometry
  localparam int unsigned MAX_LEDS  = 64;
  localparam int unsigned LED_IDX_W = $clog2(MAX_LEDS);
  localparam int unsigned LED_CNT_W = 7;

  // Field widths
  localparam int unsigned HUE_W     = 16;
  localparam int unsigned INC_W     = 15;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 15;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  // Hue is degrees times 64
  localparam logic [INC_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [11:0]      HUE_SECTOR = 12'd3840;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_COUNT  = 3'd0,
    CFG_PIXEL_INC  = 3'd1,
    CFG_FRAME_INC  = 3'd2,
    CFG_HUE_LOWER  = 3'd3,
    CFG_HUE_UPPER  = 3'd4,
    CFG_SATURATION = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] sat;
  } cu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } cu_rsp_t;

  // Add the step; past the upper limit, fold the excess onto the lower limit.
  function automatic logic [HUE_W-1:0] advance_hue(logic [HUE_W-1:0] hue,
                                                   logic [INC_W-1:0] inc,
                                                   logic [INC_W-1:0] lower,
                                                   logic [INC_W-1:0] upper);
    logic [HUE_W:0] sum;
    logic [HUE_W:0] folded;
    sum    = {1'b0, hue} + {2'b00, inc};
    folded = {2'b00, lower} + sum - {2'b00, upper};
    if (sum > {2'b00, upper}) begin
      return folded[HUE_W-1:0];
    end
    return sum[HUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/rhlg_colour_unit.sv
`default_nettype none

module rhlg_colour_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rhlg_pkg::cu_req_t req_i,
  output rhlg_pkg::cu_rsp_t rsp_o
);
  import rhlg_pkg::*;

  // 255 * 3840: common denominator of p, q and t
  localparam logic [19:0] FRAC_DEN = 20'd979200;
  localparam logic [27:0] DEN_TOP  = 28'(FRAC_DEN) << 7;

  localparam logic [14:0] B1 = 15'(HUE_SECTOR);
  localparam logic [14:0] B2 = 15'(2 * HUE_SECTOR);
  localparam logic [14:0] B3 = 15'(3 * HUE_SECTOR);
  localparam logic [14:0] B4 = 15'(4 * HUE_SECTOR);
  localparam logic [14:0] B5 = 15'(5 * HUE_SECTOR);

  typedef enum logic [2:0] {
    CU_IDLE,
    CU_MULS,
    CU_MULV,
    CU_DIV,
    CU_FIN
  } cu_state_e;

  cu_state_e   state_q;
  logic [2:0]  bit_q;
  logic [2:0]  sec_q;
  logic [11:0] frac_q;
  logic [7:0]  sat_q;      // rotated, back in place after eight steps
  logic [7:0]  val_q;      // rotated likewise
  logic [19:0] sf_q, sg_q;
  logic [27:0] np_q, nq_q, nt_q;
  logic [7:0]  qp_q, qq_q, qt_q;
  logic [7:0]  red_q, green_q, blue_q;
  logic        done_q;

  logic [14:0] hue_c;
  logic [14:0] base_c;
  logic [2:0]  sec_c;
  logic [11:0] comp_c;
  logic [19:0] ap_c, aq_c, at_c;
  logic [7:0]  inv_sat;

  // Sector and offset within it; hue at or past a full turn reads as zero
  always_comb begin
    hue_c = (req_i.hue >= {1'b0, HUE_FULL}) ? 15'd0 : req_i.hue[14:0];
    priority if (hue_c >= B5) begin
      sec_c = 3'd5; base_c = B5;
    end else if (hue_c >= B4) begin
      sec_c = 3'd4; base_c = B4;
    end else if (hue_c >= B3) begin
      sec_c = 3'd3; base_c = B3;
    end else if (hue_c >= B2) begin
      sec_c = 3'd2; base_c = B2;
    end else if (hue_c >= B1) begin
      sec_c = 3'd1; base_c = B1;
    end else begin
      sec_c = 3'd0; base_c = 15'd0;
    end
  end

  assign comp_c  = HUE_SECTOR - frac_q;
  assign inv_sat = ~sat_q;
  // (255 - s) * 3840 = (x << 12) - (x << 8); zero saturation makes all
  // three terms equal the denominator, so grey needs no special path
  assign ap_c = {inv_sat, 12'd0} - {4'd0, inv_sat, 8'd0};
  assign aq_c = FRAC_DEN - sf_q;
  assign at_c = FRAC_DEN - sg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CU_IDLE;
      bit_q   <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == CU_FIN);
      unique case (state_q)
        CU_IDLE: begin
          if (req_i.start) begin
            sec_q   <= sec_c;
            frac_q  <= 12'(hue_c - base_c);
            sat_q   <= req_i.sat;
            val_q   <= req_i.value;
            sf_q    <= '0;
            sg_q    <= '0;
            np_q    <= '0;
            nq_q    <= '0;
            nt_q    <= '0;
            bit_q   <= 3'd7;
            state_q <= CU_MULS;
          end
        end
        CU_MULS: begin
          // s * f and s * (3840 - f), one saturation bit a cycle, MSB first;
          // the step counter wraps to seven for the next pass
          sf_q  <= {sf_q[18:0], 1'b0} + (sat_q[7] ? {8'd0, frac_q} : 20'd0);
          sg_q  <= {sg_q[18:0], 1'b0} + (sat_q[7] ? {8'd0, comp_c} : 20'd0);
          sat_q <= {sat_q[6:0], sat_q[7]};
          bit_q <= bit_q - 3'd1;
          if (bit_q == 3'd0) begin
            state_q <= CU_MULV;
          end
        end
        CU_MULV: begin
          // v * term for all three channels, one value bit a cycle
          np_q  <= {np_q[26:0], 1'b0} + (val_q[7] ? {8'd0, ap_c} : 28'd0);
          nq_q  <= {nq_q[26:0], 1'b0} + (val_q[7] ? {8'd0, aq_c} : 28'd0);
          nt_q  <= {nt_q[26:0], 1'b0} + (val_q[7] ? {8'd0, at_c} : 28'd0);
          val_q <= {val_q[6:0], val_q[7]};
          bit_q <= bit_q - 3'd1;
          if (bit_q == 3'd0) begin
            state_q <= CU_DIV;
          end
        end
        CU_DIV: begin
          // Restoring division by the denominator, one quotient bit a cycle
          if (np_q >= DEN_TOP) begin
            np_q <= {np_q[26:0] - DEN_TOP[26:0], 1'b0};
            qp_q <= {qp_q[6:0], 1'b1};
          end else begin
            np_q <= {np_q[26:0], 1'b0};
            qp_q <= {qp_q[6:0], 1'b0};
          end
          if (nq_q >= DEN_TOP) begin
            nq_q <= {nq_q[26:0] - DEN_TOP[26:0], 1'b0};
            qq_q <= {qq_q[6:0], 1'b1};
          end else begin
            nq_q <= {nq_q[26:0], 1'b0};
            qq_q <= {qq_q[6:0], 1'b0};
          end
          if (nt_q >= DEN_TOP) begin
            nt_q <= {nt_q[26:0] - DEN_TOP[26:0], 1'b0};
            qt_q <= {qt_q[6:0], 1'b1};
          end else begin
            nt_q <= {nt_q[26:0], 1'b0};
            qt_q <= {qt_q[6:0], 1'b0};
          end
          bit_q <= bit_q - 3'd1;
          if (bit_q == 3'd0) begin
            state_q <= CU_FIN;
          end
        end
        CU_FIN: begin
          unique case (sec_q)
            3'd0: begin red_q <= val_q; green_q <= qt_q;  blue_q <= qp_q;  end
            3'd1: begin red_q <= qq_q;  green_q <= val_q; blue_q <= qp_q;  end
            3'd2: begin red_q <= qp_q;  green_q <= val_q; blue_q <= qt_q;  end
            3'd3: begin red_q <= qp_q;  green_q <= qq_q;  blue_q <= val_q; end
            3'd4: begin red_q <= qt_q;  green_q <= qp_q;  blue_q <= val_q; end
            default: begin red_q <= val_q; green_q <= qp_q; blue_q <= qq_q; end
          endcase
          state_q <= CU_IDLE;
        end
        default: state_q <= CU_IDLE;
      endcase
    end
  end

  assign rsp_o.busy  = (state_q != CU_IDLE);
  assign rsp_o.done  = done_q;
  assign rsp_o.red   = red_q;
  assign rsp_o.green = green_q;
  assign rsp_o.blue  = blue_q;

endmodule

`default_nettype wire

FILE: sv/rainbow_hsv_led_generator.sv
// LEDs are computed one at a time by the bit-serial multiply/divide colour unit
// (three passes of 8 steps); a new frame request is taken only once the last
// LED of the previous frame has been pushed to the output register.
// A frame request with a led_count of zero is absorbed without leaving idle.
// Reset (rst_ni low, asynchronous) clears the frame hue, loads the register
// defaults and empties the output register.
`default_nettype none

module rainbow_hsv_led_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Frame request
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [rhlg_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // [7:0] brightness
  // LED colours
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [5:0] led_index, [13:6] red, [21:14] green, [29:22] blue, [31:30] zero
  output logic [rhlg_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tlast_o,  // last_led
  // Register writes
  input  logic                                cfg_we_i,
  input  logic [rhlg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rhlg_pkg::CFG_DAT_W-1:0]      cfg_data_i
);
  import rhlg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_PUSH
  } state_e;

  // Configuration registers
  logic [LED_CNT_W-1:0] led_count_q;
  logic [INC_W-1:0]     pixel_inc_q;
  logic [INC_W-1:0]     frame_inc_q;
  logic [INC_W-1:0]     hue_lower_q;
  logic [INC_W-1:0]     hue_upper_q;
  logic [CHAN_W-1:0]    sat_q;

  // Frame sequencer
  state_e               state_q;
  logic [HUE_W-1:0]     frame_start_hue_q;
  logic [HUE_W-1:0]     hue_q;
  logic [CHAN_W-1:0]    val_q;
  logic [LED_IDX_W-1:0] idx_q;
  logic [LED_CNT_W-1:0] n_q;

  // Output register
  logic                 out_valid_q;
  logic [LED_IDX_W-1:0] out_idx_q;
  logic [CHAN_W-1:0]    out_red_q, out_green_q, out_blue_q;
  logic                 out_last_q;

  cu_req_t              cu_req;
  cu_rsp_t              cu_rsp;

  logic                 in_acc;
  logic                 out_free;
  logic                 led_push;
  logic                 is_last;
  logic [LED_CNT_W-1:0] n_clip;
  logic [HUE_W-1:0]     frame_hue_next;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign led_push        = (state_q == ST_PUSH) && out_free;
  assign is_last         = ({1'b0, idx_q} + LED_CNT_W'(1)) == n_q;

  // Counts beyond the LED string length clip to it
  assign n_clip = (led_count_q > LED_CNT_W'(MAX_LEDS)) ? LED_CNT_W'(MAX_LEDS) : led_count_q;
  assign frame_hue_next = advance_hue(frame_start_hue_q, frame_inc_q,
                                      hue_lower_q, hue_upper_q);

  assign cu_req.start = (state_q == ST_START);
  assign cu_req.hue   = hue_q;
  assign cu_req.value = val_q;
  assign cu_req.sat   = sat_q;

  rhlg_colour_unit u_colour (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cu_req),
    .rsp_o  (cu_rsp)
  );

  // Register file: the host must write only while no frame is in flight; not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= LED_CNT_W'(1);
      pixel_inc_q <= '0;
      frame_inc_q <= '0;
      hue_lower_q <= '0;
      hue_upper_q <= HUE_FULL;
      sat_q       <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LED_COUNT:  led_count_q <= cfg_data_i[LED_CNT_W-1:0];
        CFG_PIXEL_INC:  pixel_inc_q <= cfg_data_i;
        CFG_FRAME_INC:  frame_inc_q <= cfg_data_i;
        CFG_HUE_LOWER:  hue_lower_q <= cfg_data_i;
        CFG_HUE_UPPER:  hue_upper_q <= cfg_data_i;
        CFG_SATURATION: sat_q       <= cfg_data_i[CHAN_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Frame sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      frame_start_hue_q <= '0;
      out_valid_q       <= 1'b0;
      idx_q             <= '0;
      n_q               <= '0;
    end else begin
      // Load on a push, drop the held item once the sink takes it
      if (led_push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            val_q <= s_axis_tdata_i[CHAN_W-1:0];
            hue_q <= frame_start_hue_q;
            idx_q <= '0;
            n_q   <= n_clip;
            if (n_clip == '0) begin
              // Empty frame: no LEDs, but advance the frame hue anyway
              frame_start_hue_q <= frame_hue_next;
            end else begin
              state_q <= ST_START;
            end
          end
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (cu_rsp.done) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          // Hold the colour in the unit until the output slot frees up
          if (out_free) begin
            out_idx_q   <= idx_q;
            out_red_q   <= cu_rsp.red;
            out_green_q <= cu_rsp.green;
            out_blue_q  <= cu_rsp.blue;
            out_last_q  <= is_last;
            hue_q       <= advance_hue(hue_q, pixel_inc_q, hue_lower_q, hue_upper_q);
            idx_q       <= idx_q + LED_IDX_W'(1);
            if (is_last) begin
              frame_start_hue_q <= frame_hue_next;
              state_q           <= ST_IDLE;
            end else begin
              state_q <= ST_START;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_blue_q, out_green_q, out_red_q, out_idx_q};

  // The colour unit is only started while it is idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cu_req.start |-> !cu_rsp.busy)
    else $error("colour unit started while busy");

  // A finished colour only shows up while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cu_rsp.done |-> state_q == ST_WAIT)
    else $error("colour result arrived outside wait state");

  // While a frame runs, the LED index stays below the frame length
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> {1'b0, idx_q} < n_q)
    else $error("LED index ran past frame length");

  // The stored frame hue only moves at the end of a frame
  a_hue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT |=> $stable(frame_start_hue_q))
    else $error("frame hue changed mid-frame");

endmodule

`default_nettype wire

FILE: sim/rhlg_frame_checker.sv
`default_nettype none

module rhlg_frame_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [rhlg_pkg::IN_DATA_W-1:0]    in_data_i,   // [7:0] brightness
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  // [5:0] led_index, [13:6] red, [21:14] green, [29:22] blue, [31:30] zero
  input  logic [rhlg_pkg::OUT_DATA_W-1:0]   out_data_i,
  input  logic                              out_last_i,  // last_led
  input  logic                              cfg_we_i,
  input  logic [rhlg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rhlg_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  output int                                pending_o,
  output int                                errors_o
);

  typedef struct {
    logic [5:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;
  } led_color_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int unsigned HUE_TURN = 23040;
  localparam int unsigned SECTOR   = 3840;
  localparam int unsigned FRAC_DEN = 255 * 3840;

  logic [6:0]  led_count;
  logic [14:0] pixel_step;
  logic [14:0] frame_step;
  logic [14:0] hue_floor;
  logic [14:0] hue_ceil;
  logic [7:0]  saturation;
  logic [15:0] frame_hue;

  led_color_t  colors_due[$];
  int          mismatches;

  // One hue advance, folded once past the upper limit, kept to 16 bits.
  function automatic logic [15:0] step_hue(input logic [15:0] hue, input logic [14:0] inc,
                                           input logic [14:0] lo, input logic [14:0] hi);
    logic [31:0] x;
    x = 32'(hue) + 32'(inc);
    if (x > 32'(hi)) x = 32'(lo) + (x - 32'(hi));
    return x[15:0];
  endfunction

  function automatic rgb_t hsv_pixel(input logic [15:0] hue, input logic [7:0] value,
                                     input logic [7:0] sat);
    logic [31:0] h, v, s, f, p, q, t;
    rgb_t        px;
    h = 32'(hue);
    v = 32'(value);
    s = 32'(sat);
    if (s == 0) begin
      px = {value, value, value};
      return px;
    end
    if (h >= HUE_TURN) h = 0;
    f = h % SECTOR;
    p = v * (255 - s) / 255;
    q = v * (FRAC_DEN - s * f) / FRAC_DEN;
    t = v * (FRAC_DEN - s * (SECTOR - f)) / FRAC_DEN;
    case (h / SECTOR)
      0:       px = {v[7:0], t[7:0], p[7:0]};
      1:       px = {q[7:0], v[7:0], p[7:0]};
      2:       px = {p[7:0], v[7:0], t[7:0]};
      3:       px = {p[7:0], q[7:0], v[7:0]};
      4:       px = {t[7:0], p[7:0], v[7:0]};
      default: px = {v[7:0], p[7:0], q[7:0]};
    endcase
    return px;
  endfunction

  task automatic predict_frame(input logic [7:0] value);
    int unsigned n;
    logic [15:0] hue;
    rgb_t        px;
    led_color_t  led;
    n   = (led_count > rhlg_pkg::MAX_LEDS) ? rhlg_pkg::MAX_LEDS : led_count;
    hue = frame_hue;
    for (int unsigned k = 0; k < n; k++) begin
      px            = hsv_pixel(hue, value, saturation);
      led.led_index = k[5:0];
      led.red       = px.red;
      led.green     = px.green;
      led.blue      = px.blue;
      led.last_led  = (k + 1 == n);
      colors_due.push_back(led);
      hue = step_hue(hue, pixel_step, hue_floor, hue_ceil);
    end
    frame_hue = step_hue(frame_hue, frame_step, hue_floor, hue_ceil);
  endtask

  task automatic check_led();
    led_color_t want;
    if (colors_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected LED item: data %h last %b", out_data_i, out_last_i);
      return;
    end
    want = colors_due.pop_front();
    if (out_data_i[5:0] !== want.led_index || out_data_i[13:6] !== want.red ||
        out_data_i[21:14] !== want.green || out_data_i[29:22] !== want.blue ||
        out_data_i[31:30] !== 2'b00 || out_last_i !== want.last_led) begin
      mismatches++;
      if (mismatches <= 10)
        $display("LED mismatch: expected idx %0d rgb %0d %0d %0d last %b pad 0, got idx %0d rgb %0d %0d %0d last %b pad %0d",
                 want.led_index, want.red, want.green, want.blue, want.last_led,
                 out_data_i[5:0], out_data_i[13:6], out_data_i[21:14], out_data_i[29:22],
                 out_last_i, out_data_i[31:30]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count  = 7'd1;
      pixel_step = '0;
      frame_step = '0;
      hue_floor  = '0;
      hue_ceil   = 15'd23040;
      saturation = 8'd255;
      frame_hue  = '0;
      colors_due.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (rhlg_pkg::cfg_idx_e'(cfg_idx_i))
          rhlg_pkg::CFG_LED_COUNT:  led_count  = cfg_data_i[6:0];
          rhlg_pkg::CFG_PIXEL_INC:  pixel_step = cfg_data_i;
          rhlg_pkg::CFG_FRAME_INC:  frame_step = cfg_data_i;
          rhlg_pkg::CFG_HUE_LOWER:  hue_floor  = cfg_data_i;
          rhlg_pkg::CFG_HUE_UPPER:  hue_ceil   = cfg_data_i;
          rhlg_pkg::CFG_SATURATION: saturation = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_frame(in_data_i);
      if (out_valid_i && out_ready_i) check_led();
      pending_o <= colors_due.size();
      errors_o  <= mismatches;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;

  localparam int SETTLE       = 64;          // well past the first-LED latency
  localparam int LIMIT        = 10_000_000;  // cycle budget for the whole run
  localparam int RANDOM_ITEMS = 300;
  localparam logic [rhlg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_STALLS} rx_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [rhlg_pkg::IN_DATA_W-1:0]    s_tdata  = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [rhlg_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                              m_tlast;
  logic                              cfg_we   = 1'b0;
  logic [rhlg_pkg::CFG_IDX_W-1:0]    cfg_idx  = '0;
  logic [rhlg_pkg::CFG_DAT_W-1:0]    cfg_data = '0;

  int       pending;
  int       errors;
  int       cycles     = 0;
  rx_mode_e rx_mode    = RX_OPEN;
  int       stall_left = 0;
  int       burst_left = 0;
  bit       gaps_on    = 1'b1;

  rainbow_hsv_led_generator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // Predict and compare every LED item; the top only drives and judges.
  rhlg_frame_checker frame_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .out_last_i  (m_tlast),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: always open, choppy, or long stalls, picked per phase.
  always @(posedge clk) begin
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          m_tready   <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 40);
        end
      end
    endcase
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hold the write enable high; the caller drops it after the last register.
  task automatic cfg_put(input logic [rhlg_pkg::CFG_IDX_W-1:0] idx,
                         input logic [rhlg_pkg::CFG_DAT_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [14:0] lc, input logic [14:0] pinc,
                            input logic [14:0] finc, input logic [14:0] lo,
                            input logic [14:0] hi, input logic [14:0] sat,
                            input bit poke_unused);
    cfg_put(rhlg_pkg::CFG_LED_COUNT, lc);
    cfg_put(rhlg_pkg::CFG_PIXEL_INC, pinc);
    cfg_put(rhlg_pkg::CFG_FRAME_INC, finc);
    cfg_put(rhlg_pkg::CFG_HUE_LOWER, lo);
    cfg_put(rhlg_pkg::CFG_HUE_UPPER, hi);
    cfg_put(rhlg_pkg::CFG_SATURATION, sat);
    // a write to an index with no register behind it must change nothing
    if (poke_unused) cfg_put(CFG_UNUSED, 15'h7fff);
    cfg_we <= 1'b0;
  endtask

  // Offer one frame request, wait for the handshake, then drop valid for any gap asked.
  task automatic send_item(input logic [7:0] level, input int gap);
    s_tvalid <= 1'b1;
    s_tdata  <= level;
    do @(posedge clk); while (!s_tready);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Bursts of back-to-back requests separated by random gaps.
  task automatic next_gap(output int gap);
    gap = 0;
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 8);
    gap        = $urandom_range(1, 60);
  endtask

  // Drain all LED items, then let a zero-length frame finish before moving on.
  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [14:0] pick_hue();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 15'd0;
    if (pick == 1) return 15'd23040;
    if (pick == 2) return 15'($urandom_range(0, 32767));
    return 15'($urandom_range(0, 23040));
  endfunction

  initial begin
    int          sent;
    int          phase;
    int          count;
    int          gap;
    int          pick;
    logic [14:0] lc, pinc, finc, lo, hi, sat;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: one LED, hue 0, full saturation; darkest and brightest.
    send_item(8'd0, 0);
    send_item(8'd255, 1);
    wait_idle();

    // Walk all six sectors with a nonzero fraction, frame hue moving.
    rx_mode <= RX_CHOPPY;
    write_regs(15'd6, 15'd3841, 15'd1000, 15'd0, 15'd23040, 15'd255, 1'b0);
    send_item(8'd255, 0);
    send_item(8'd0, 0);
    send_item(8'd128, 1);
    wait_idle();

    // Zero saturation gives grey.
    write_regs(15'd2, 15'd1000, 15'd0, 15'd0, 15'd23040, 15'd0, 1'b0);
    send_item(8'd200, 0);
    send_item(8'd255, 1);
    wait_idle();

    // Full-turn steps: each step passes 360 degrees and folds onto the lower limit.
    rx_mode <= RX_STALLS;
    write_regs(15'd4, 15'd23040, 15'd23040, 15'd100, 15'd23040, 15'd200, 1'b0);
    send_item(8'd255, 0);
    send_item(8'd77, 3);
    send_item(8'd1, 1);
    wait_idle();

    // Limits swapped and past 360 degrees; the 16-bit hue wraps.
    write_regs(15'd3, 15'd32767, 15'd32767, 15'd32767, 15'd0, 15'd1, 1'b1);
    send_item(8'd255, 0);
    send_item(8'd254, 0);
    send_item(8'd255, 1);
    wait_idle();

    // No LEDs: nothing comes out, but the frame hue still advances.
    rx_mode <= RX_OPEN;
    write_regs(15'd0, 15'd500, 15'd5000, 15'd0, 15'd23040, 15'd255, 1'b0);
    send_item(8'd10, 0);
    send_item(8'd20, 1);
    wait_idle();

    // Count above the maximum, with junk above the count field: clamp to 64.
    write_regs(15'h7fc1, 15'd360, 15'd0, 15'd0, 15'd23040, 15'd128, 1'b0);
    send_item(8'd255, 1);
    wait_idle();

    // Exactly the maximum number of LEDs.
    rx_mode <= RX_CHOPPY;
    write_regs(15'd64, 15'd23040, 15'd0, 15'd0, 15'd23040, 15'd255, 1'b0);
    send_item(8'd99, 1);
    wait_idle();

    // Random phases: mostly short frames, now and then the longest or empty ones.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      lc = 15'd0;
      else if (pick == 1) lc = 15'($urandom_range(64, 127));
      else                lc = 15'($urandom_range(1, 8));
      if ($urandom_range(0, 3) == 0) lc[14:7] = 8'($urandom);
      pinc = pick_hue();
      finc = pick_hue();
      if ($urandom_range(0, 3) != 0) begin
        lo = 15'($urandom_range(0, 4000));
        hi = 15'($urandom_range(19000, 23040));
      end else begin
        lo = pick_hue();
        hi = pick_hue();
      end
      pick = $urandom_range(0, 5);
      if (pick == 0)      sat = 15'd0;
      else if (pick == 1) sat = 15'd255;
      else                sat = 15'($urandom_range(0, 255));
      write_regs(lc, pinc, finc, lo, hi, sat, $urandom_range(0, 7) == 0);

      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      gaps_on  = ($urandom_range(0, 3) != 0);
      count    = $urandom_range(8, 24);
      for (int i = 0; i < count; i++) begin
        next_gap(gap);
        // drop valid at the end of the phase and before the mid-phase drain
        if ((i == count - 1 || (phase == 1 && i == count / 2)) && gap == 0) gap = 1;
        send_item(8'($urandom), gap);
        if (phase == 1 && i == count / 2) begin
          do @(posedge clk); while (pending != 0);
        end
      end
      sent += count;
      wait_idle();
      phase++;
    end

    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
